>>> hdl/srgbds_pkg.sv
// shared types, constants and conversion tables of the srgb box downsampler
package srgbds_pkg;

	localparam int MAX_LOG2  = 11;
	localparam int NUM_STAGES = MAX_LOG2;
	localparam int LIN_BITS  = 16;
	localparam int PAIR_W    = LIN_BITS + 1;
	localparam int SUM_W     = LIN_BITS + 2;
	localparam int POS_W     = MAX_LOG2;
	localparam int CFG_W     = 4;
	localparam int IDX_W     = 2;
	localparam int PIX_W     = 24;

	localparam logic [IDX_W-1:0] REG_SIZE_LOG2 = 2'd0;
	localparam logic [IDX_W-1:0] REG_LEVELS    = 2'd1;

	localparam logic [CFG_W-1:0] SIZE_RESET   = 4'd9;
	localparam logic [CFG_W-1:0] LEVELS_RESET = 4'd1;

	typedef logic [LIN_BITS-1:0] lin_rom_t [256];
	typedef logic [SUM_W-1:0] thr_rom_t [256];

	// one beat between downsampling stages
	typedef struct packed {
		logic             v;
		logic             rej;
		logic [PIX_W-1:0] pix;
	} beat_t;

	function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
		return (a * b) >> 30;
	endfunction

	function automatic longint unsigned pow5(longint unsigned r);
		longint unsigned r2;
		longint unsigned r4;
		r2 = qmul(r, r);
		r4 = qmul(r2, r2);
		return qmul(r4, r);
	endfunction

	// linear light of num/255 (half = 0) or num/510 (half = 1) in q30
	function automatic longint unsigned decode_q30(longint unsigned num, bit half);
		longint unsigned base;
		longint unsigned base2;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		longint unsigned x;
		if (half) begin
			if (num * 100000 <= 64'd2062950)
				return ((num << 30) * 100) / 64'd658920;
			x = (1000 * num + 64'd28050) << 30;
			base = x / 64'd538050;
		end else begin
			if (num * 100000 <= 64'd1031475)
				return ((num << 30) * 100) / 64'd329460;
			x = (1000 * num + 64'd14025) << 30;
			base = x / 64'd269025;
		end
		if (base > (64'd1 << 30))
			base = 64'd1 << 30;
		base2 = qmul(base, base);
		lo = 0;
		hi = 64'd1 << 30;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (pow5(mid) <= base2)
				lo = mid;
			else
				hi = mid - 1;
		end
		return qmul(base2, lo);
	endfunction

	function automatic lin_rom_t build_lin_rom();
		lin_rom_t rom;
		longint unsigned r;
		for (int e = 0; e < 256; e++) begin
			r = (decode_q30(longint'(e), 1'b0) + (64'd1 << (29 - LIN_BITS))) >> (30 - LIN_BITS);
			if (r > ((64'd1 << LIN_BITS) - 1))
				r = (64'd1 << LIN_BITS) - 1;
			rom[e] = r[LIN_BITS-1:0];
		end
		return rom;
	endfunction

	function automatic thr_rom_t build_thr_rom();
		thr_rom_t rom;
		longint unsigned q;
		longint unsigned r;
		rom[0] = '0;
		for (int t = 1; t < 256; t++) begin
			q = decode_q30(longint'(2 * t - 1), 1'b1);
			r = (q + (64'd1 << (28 - LIN_BITS)) - 1) >> (28 - LIN_BITS);
			rom[t] = r[SUM_W-1:0];
		end
		return rom;
	endfunction

	localparam lin_rom_t LIN_ROM = build_lin_rom();
	localparam thr_rom_t THR_ROM = build_thr_rom();

	// count of thresholds reached, by binary search over the rising table
	function automatic logic [7:0] encode_sum(logic [SUM_W-1:0] s);
		logic [7:0] code;
		logic [7:0] trial;
		code = '0;
		for (int b = 7; b >= 0; b--) begin
			trial = code | (8'd1 << b);
			if (s >= THR_ROM[trial])
				code = trial;
		end
		return code;
	endfunction

endpackage

>>> hdl/srgbds_stage.sv
// one halving level: line memory of row pair sums, block sum and srgb encode
module srgbds_stage #(
	parameter int LEVEL     = 0,
	parameter int PAIR_BITS = srgbds_pkg::MAX_LOG2 - 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          clr,
	input  logic [srgbds_pkg::CFG_W-1:0]  size_log2,
	input  logic [srgbds_pkg::CFG_W-1:0]  levels,
	input  srgbds_pkg::beat_t             in_beat,
	output srgbds_pkg::beat_t             out_beat
);

	localparam int PW = srgbds_pkg::PAIR_W;
	localparam int SW = srgbds_pkg::SUM_W;
	localparam int LW = srgbds_pkg::LIN_BITS;
	localparam int XW = srgbds_pkg::POS_W;

	logic          active;
	logic          take;
	logic [3:0]    shift;
	logic [XW:0]   span_full;
	logic [XW-1:0] span_m1;
	logic [XW-1:0] col_q, row_q;
	logic          col_end, row_end;
	logic [PAIR_BITS-1:0] addr;

	logic [LW-1:0]   lin   [3];
	logic [LW-1:0]   left_q [3];
	logic [PW-1:0]   pair_sum [3];
	logic [3*PW-1:0] wr_word;
	logic [3*PW-1:0] mem [2**PAIR_BITS];
	logic [3*PW-1:0] rd_q;

	logic                        v_s1, byp_s1, rej_s1;
	logic [srgbds_pkg::PIX_W-1:0] pix_s1;
	logic [PW-1:0]               sum_s1 [3];
	logic                        v_s2, byp_s2, rej_s2;
	logic [srgbds_pkg::PIX_W-1:0] pix_s2;
	logic [SW-1:0]               blk_s2 [3];
	logic                        v_s3, rej_s3;
	logic [srgbds_pkg::PIX_W-1:0] pix_s3;

	function automatic logic [3:0] CFG_W_LEVEL();
		return 4'(LEVEL);
	endfunction

	// position within this level's input image
	assign active    = levels > CFG_W_LEVEL();
	assign take      = en && in_beat.v && !in_beat.rej && active;
	assign shift     = size_log2 - CFG_W_LEVEL();
	assign span_full = (XW+1)'(1) << shift;
	assign span_m1   = XW'(span_full - (XW+1)'(1));
	assign col_end   = col_q == span_m1;
	assign row_end   = row_q == span_m1;
	assign addr      = col_q[PAIR_BITS:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (clr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + XW'(1);
			end else begin
				col_q <= col_q + XW'(1);
			end
		end
	end

	// linearize and pair with the left neighbor
	for (genvar c = 0; c < 3; c++) begin : g_chan
		assign lin[c]      = srgbds_pkg::LIN_ROM[in_beat.pix[8*c +: 8]];
		assign pair_sum[c] = {1'b0, lin[c]} + {1'b0, left_q[c]};
		assign wr_word[PW*c +: PW] = pair_sum[c];

		always_ff @(posedge clk) begin
			if (take && !col_q[0])
				left_q[c] <= lin[c];
		end
	end

	// row pair memory: written on even rows, read back on odd rows
	always_ff @(posedge clk) begin
		if (take && col_q[0] && !row_q[0])
			mem[addr] <= wr_word;
		if (en)
			rd_q <= mem[addr];
	end

	// stage 1: pair sum alongside the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_beat.v && (in_beat.rej || !active || (col_q[0] && row_q[0]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			byp_s1 <= in_beat.rej || !active;
			rej_s1 <= in_beat.rej;
			pix_s1 <= in_beat.pix;
			for (int c = 0; c < 3; c++)
				sum_s1[c] <= pair_sum[c];
		end
	end

	// stage 2: block sum of four
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			byp_s2 <= byp_s1;
			rej_s2 <= rej_s1;
			pix_s2 <= pix_s1;
			for (int c = 0; c < 3; c++)
				blk_s2[c] <= {1'b0, sum_s1[c]} + {1'b0, rd_q[PW*c +: PW]};
		end
	end

	// stage 3: back to srgb codes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rej_s3 <= rej_s2;
			for (int c = 0; c < 3; c++)
				pix_s3[8*c +: 8] <= byp_s2 ? pix_s2[8*c +: 8] : srgbds_pkg::encode_sum(blk_s2[c]);
		end
	end

	assign out_beat.v   = v_s3;
	assign out_beat.rej = rej_s3;
	assign out_beat.pix = pix_s3;

endmodule

>>> hdl/srgb_linear_box_downsampler.sv
// top level: config registers, chain of halving stages and output register
// pipeline: each of the 11 level stages holds 3 registers (stage 1, 2 and 3),
// followed by the output register; inactive stages pass through
// throughput: one pixel per cycle while the output is not stalled, a level's
// line memory is read and written in the same cycle as its input beat
// reset: asynchronous active low, registers return to size 512 and one level
module srgb_linear_box_downsampler (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [23:0]                      s_axis_tdata,   // in_red, in_green, in_blue
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [23:0]                      m_axis_tdata,   // out_red, out_green, out_blue
	output logic                             m_axis_tlast,
	output logic                             m_axis_tuser,   // rejected
	input  logic                             cfg_we,
	input  logic [srgbds_pkg::IDX_W-1:0]     cfg_index,
	input  logic [srgbds_pkg::CFG_W-1:0]     cfg_data
);

	localparam int XW = srgbds_pkg::POS_W;
	localparam int NS = srgbds_pkg::NUM_STAGES;

	logic [srgbds_pkg::CFG_W-1:0] size_q, levels_q;
	logic                         cfg_rej;
	logic                         en;
	srgbds_pkg::beat_t            chain [NS+1];
	srgbds_pkg::beat_t            fin;

	logic          out_v_q, out_rej_q, out_last_q;
	logic [23:0]   out_pix_q;
	logic [XW-1:0] col_q, row_q;
	logic [3:0]    shift;
	logic [XW:0]   span_full;
	logic [XW-1:0] span_m1;
	logic          col_end, row_end;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= srgbds_pkg::SIZE_RESET;
			levels_q <= srgbds_pkg::LEVELS_RESET;
		end else if (cfg_we) begin
			if (cfg_index == srgbds_pkg::REG_SIZE_LOG2)
				size_q <= cfg_data;
			else if (cfg_index == srgbds_pkg::REG_LEVELS)
				levels_q <= cfg_data;
		end
	end

	assign cfg_rej = (size_q > 4'(srgbds_pkg::MAX_LOG2)) || (levels_q > size_q);

	// whole chain advances together while the output register can take a beat
	assign en            = !out_v_q || m_axis_tready;
	assign s_axis_tready = en;

	assign chain[0].v   = s_axis_tvalid;
	assign chain[0].rej = cfg_rej;
	assign chain[0].pix = s_axis_tdata;

	for (genvar l = 0; l < NS; l++) begin : g_stage
		localparam int PB = (srgbds_pkg::MAX_LOG2 - 1 - l) > 0 ?
			(srgbds_pkg::MAX_LOG2 - 1 - l) : 1;
		srgbds_stage #(
			.LEVEL     (l),
			.PAIR_BITS (PB)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.clr       (cfg_we),
			.size_log2 (size_q),
			.levels    (levels_q),
			.in_beat   (chain[l]),
			.out_beat  (chain[l+1])
		);
	end

	assign fin = chain[NS];

	// output image position for the last pixel flag
	assign shift     = size_q - levels_q;
	assign span_full = (XW+1)'(1) << shift;
	assign span_m1   = XW'(span_full - (XW+1)'(1));
	assign col_end   = col_q == span_m1;
	assign row_end   = row_q == span_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we) begin
			col_q <= '0;
			row_q <= '0;
		end else if (en && fin.v && !fin.rej) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + XW'(1);
			end else begin
				col_q <= col_q + XW'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (en)
			out_v_q <= fin.v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_rej_q  <= fin.rej;
			out_pix_q  <= fin.rej ? '0 : fin.pix;
			out_last_q <= !fin.rej && col_end && row_end;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_pix_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_rej_q;

endmodule

>>> hdl/srgbds_chk.sv
// port level checks of the srgb box downsampler
module srgbds_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        m_axis_tuser
);

	// held result beat stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// a refused beat carries no color and no frame end
	a_rej: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 24'd0 && !m_axis_tlast)
		else $error("rejected beat with data");

	// input side stalls only behind a stalled result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready out of step with output");

	// nothing comes out after a reset cycle
	a_reset: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("result beat during reset");

endmodule

bind srgb_linear_box_downsampler srgbds_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
